### rtl/dnsq_pkg.sv
// dnsq_pkg: shared types and constants of the dns question parser
package dnsq_pkg;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_CHAR   = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_SHORT_HEADER = 3'd0,
    ERR_NO_QUESTIONS = 3'd1,
    ERR_BAD_NAME     = 3'd2,
    ERR_POINTER      = 3'd3,
    ERR_TOO_LONG     = 3'd4
  } err_e;

  typedef enum logic [5:0] {
    PH_HEADER      = 6'b000001,
    PH_LABEL_LEN   = 6'b000010,
    PH_LABEL_BYTES = 6'b000100,
    PH_TAIL        = 6'b001000,
    PH_DONE        = 6'b010000,
    PH_ERROR       = 6'b100000
  } phase_e;

  localparam int unsigned HDR_WORDS  = 6;
  localparam logic [3:0]  HDR_LAST   = 4'd11;
  localparam logic [1:0]  TAIL_LAST  = 2'd3;
  localparam logic [1:0]  PTR_MARK   = 2'b11;
  localparam logic [7:0]  DOT_CHAR   = 8'h2e;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // one queue word: up to one plain result followed by an optional error
  typedef struct packed {
    logic                        first_vld;
    kind_e                       first_kind;
    logic [HDR_WORDS-1:0][15:0]  words;
    logic [7:0]                  chr;
    logic                        err_vld;
    err_e                        err_code;
    logic                        last;
  } entry_t;

endpackage

### rtl/dns_question_parser.sv
// dns_question_parser: top level of the dns query header and question parser
//
// Input channel: one message byte per word, with end_of_packet_i on the last
// byte. A word is taken on a rising edge with push high and full low.
// Result channel: header, name character, question done and error words,
// oldest first; the head word is on the ports while empty is low and is taken
// on a rising edge with pop high.
// The results of a byte are on the ports from the cycle after the byte is
// taken, when the queue was empty.
// Throughput: one byte per cycle. A byte gives at most two results; one that
// gives two needs two pops, so the sustained byte rate follows the pop rate.
// The parser and the output side are parted by a four-word queue; full rises
// when it holds four unread words, and the parser then waits.
// Reset clears the parser and the queue; the next byte starts a new message.
// Every message is also closed by its end_of_packet byte, which returns the
// parser to the header phase.
module dns_question_parser #(
  parameter int unsigned MAX_NAME_BYTES = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_packet_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  item_kind_o,
  output logic [15:0] message_id_o,
  output logic [15:0] header_flags_o,
  output logic [15:0] question_count_o,
  output logic [15:0] answer_count_o,
  output logic [15:0] authority_count_o,
  output logic [15:0] additional_count_o,
  output logic [7:0]  name_char_o,
  output logic [15:0] query_type_o,
  output logic [15:0] query_class_o,
  output logic [2:0]  error_code_o,
  output logic        last_of_packet_o
);

  logic             accept;
  logic             fifo_push;
  logic             fifo_pop;
  logic             fifo_empty;
  dnsq_pkg::entry_t fifo_wdata;
  dnsq_pkg::entry_t fifo_rdata;

  assign accept = push && !full;

  dnsq_front #(
    .MAX_NAME_BYTES (MAX_NAME_BYTES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .end_of_packet_i (end_of_packet_i),
    .push_o          (fifo_push),
    .entry_o         (fifo_wdata)
  );

  dnsq_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .wdata_i (fifo_wdata),
    .pop_i   (fifo_pop),
    .rdata_o (fifo_rdata),
    .full_o  (full),
    .empty_o (fifo_empty)
  );

  dnsq_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_i             (fifo_rdata),
    .fifo_empty_i       (fifo_empty),
    .fifo_pop_o         (fifo_pop),
    .pop_i              (pop),
    .empty_o            (empty),
    .item_kind_o        (item_kind_o),
    .message_id_o       (message_id_o),
    .header_flags_o     (header_flags_o),
    .question_count_o   (question_count_o),
    .answer_count_o     (answer_count_o),
    .authority_count_o  (authority_count_o),
    .additional_count_o (additional_count_o),
    .name_char_o        (name_char_o),
    .query_type_o       (query_type_o),
    .query_class_o      (query_class_o),
    .error_code_o       (error_code_o),
    .last_of_packet_o   (last_of_packet_o)
  );

endmodule

### rtl/dnsq_front.sv
// dnsq_front: byte-level parser that turns each byte into at most one queue word
module dnsq_front #(
  parameter int unsigned MAX_NAME_BYTES = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         data_byte_i,
  input  logic               end_of_packet_i,
  output logic               push_o,
  output dnsq_pkg::entry_t   entry_o
);

  localparam int unsigned NLW = $clog2(MAX_NAME_BYTES + 1);

  dnsq_pkg::phase_e                          phase_q, phase_d;
  logic [3:0]                                hdr_cnt_q, hdr_cnt_d;
  logic [dnsq_pkg::HDR_WORDS-1:0][15:0]      hdr_words_q, hdr_words_d;
  logic [15:0]                               q_left_q, q_left_d;
  logic [7:0]                                lbl_left_q, lbl_left_d;
  logic [NLW-1:0]                            name_len_q, name_len_d;
  logic                                      started_q, started_d;
  logic [31:0]                               tc_q, tc_d;
  logic [1:0]                                tail_cnt_q, tail_cnt_d;
  logic [2:0]                                hdr_idx;
  logic                                      too_long;
  dnsq_pkg::entry_t                          ent;

  assign hdr_idx  = hdr_cnt_q[3:1];
  assign too_long = (name_len_q == NLW'(MAX_NAME_BYTES));

  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    hdr_words_d = hdr_words_q;
    q_left_d    = q_left_q;
    lbl_left_d  = lbl_left_q;
    name_len_d  = name_len_q;
    started_d   = started_q;
    tc_d        = tc_q;
    tail_cnt_d  = tail_cnt_q;
    ent         = '0;
    if (accept_i) begin
      unique case (phase_q) inside
        dnsq_pkg::PH_HEADER: begin
          hdr_words_d[hdr_idx] = {hdr_words_q[hdr_idx][7:0], data_byte_i};
          hdr_cnt_d = hdr_cnt_q + 4'd1;
          if (hdr_cnt_q == dnsq_pkg::HDR_LAST) begin
            ent.first_vld  = 1'b1;
            ent.first_kind = dnsq_pkg::KIND_HEADER;
            ent.words      = hdr_words_d;
            q_left_d       = hdr_words_d[2];
            if (hdr_words_d[2] == 16'd0) begin
              ent.err_vld  = 1'b1;
              ent.err_code = dnsq_pkg::ERR_NO_QUESTIONS;
              phase_d      = dnsq_pkg::PH_ERROR;
            end else begin
              phase_d = dnsq_pkg::PH_LABEL_LEN;
            end
          end
        end
        dnsq_pkg::PH_LABEL_LEN: begin
          if (data_byte_i == 8'd0) begin
            if (!started_q) begin
              ent.err_vld  = 1'b1;
              ent.err_code = dnsq_pkg::ERR_BAD_NAME;
              phase_d      = dnsq_pkg::PH_ERROR;
            end else begin
              phase_d    = dnsq_pkg::PH_TAIL;
              tail_cnt_d = '0;
              tc_d       = '0;
            end
          end else if (data_byte_i[7:6] == dnsq_pkg::PTR_MARK) begin
            ent.err_vld  = 1'b1;
            ent.err_code = dnsq_pkg::ERR_POINTER;
            phase_d      = dnsq_pkg::PH_ERROR;
          end else if (started_q && too_long) begin
            ent.err_vld  = 1'b1;
            ent.err_code = dnsq_pkg::ERR_TOO_LONG;
            phase_d      = dnsq_pkg::PH_ERROR;
          end else begin
            if (started_q) begin
              ent.first_vld  = 1'b1;
              ent.first_kind = dnsq_pkg::KIND_CHAR;
              ent.chr        = dnsq_pkg::DOT_CHAR;
              name_len_d     = name_len_q + NLW'(1);
            end
            started_d  = 1'b1;
            lbl_left_d = data_byte_i;
            phase_d    = dnsq_pkg::PH_LABEL_BYTES;
          end
        end
        dnsq_pkg::PH_LABEL_BYTES: begin
          if (too_long) begin
            ent.err_vld  = 1'b1;
            ent.err_code = dnsq_pkg::ERR_TOO_LONG;
            phase_d      = dnsq_pkg::PH_ERROR;
          end else begin
            ent.first_vld  = 1'b1;
            ent.first_kind = dnsq_pkg::KIND_CHAR;
            ent.chr        = data_byte_i;
            name_len_d     = name_len_q + NLW'(1);
            lbl_left_d     = lbl_left_q - 8'd1;
            if (lbl_left_q == 8'd1) begin
              phase_d = dnsq_pkg::PH_LABEL_LEN;
            end
          end
        end
        dnsq_pkg::PH_TAIL: begin
          tc_d       = {tc_q[23:0], data_byte_i};
          tail_cnt_d = tail_cnt_q + 2'd1;
          if (tail_cnt_q == dnsq_pkg::TAIL_LAST) begin
            ent.first_vld  = 1'b1;
            ent.first_kind = dnsq_pkg::KIND_DONE;
            ent.words[0]   = tc_d[31:16];
            ent.words[1]   = tc_d[15:0];
            q_left_d       = q_left_q - 16'd1;
            tail_cnt_d     = '0;
            tc_d           = '0;
            name_len_d     = '0;
            started_d      = 1'b0;
            lbl_left_d     = '0;
            phase_d        = (q_left_q == 16'd1) ? dnsq_pkg::PH_DONE
                                                 : dnsq_pkg::PH_LABEL_LEN;
          end
        end
        dnsq_pkg::PH_DONE, dnsq_pkg::PH_ERROR: begin
        end
        default: begin
        end
      endcase
      if (end_of_packet_i) begin
        if (phase_d == dnsq_pkg::PH_HEADER) begin
          ent.err_vld  = 1'b1;
          ent.err_code = dnsq_pkg::ERR_SHORT_HEADER;
        end else if (phase_d == dnsq_pkg::PH_LABEL_LEN ||
                     phase_d == dnsq_pkg::PH_LABEL_BYTES ||
                     phase_d == dnsq_pkg::PH_TAIL) begin
          ent.err_vld  = 1'b1;
          ent.err_code = dnsq_pkg::ERR_BAD_NAME;
        end
        ent.last    = 1'b1;
        phase_d     = dnsq_pkg::PH_HEADER;
        hdr_cnt_d   = '0;
        hdr_words_d = '0;
        q_left_d    = '0;
        lbl_left_d  = '0;
        name_len_d  = '0;
        started_d   = 1'b0;
        tc_d        = '0;
        tail_cnt_d  = '0;
      end
    end
  end

  assign push_o  = accept_i && (ent.first_vld || ent.err_vld);
  assign entry_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= dnsq_pkg::PH_HEADER;
      hdr_cnt_q   <= '0;
      hdr_words_q <= '0;
      q_left_q    <= '0;
      lbl_left_q  <= '0;
      name_len_q  <= '0;
      started_q   <= 1'b0;
      tc_q        <= '0;
      tail_cnt_q  <= '0;
    end else begin
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      hdr_words_q <= hdr_words_d;
      q_left_q    <= q_left_d;
      lbl_left_q  <= lbl_left_d;
      name_len_q  <= name_len_d;
      started_q   <= started_d;
      tc_q        <= tc_d;
      tail_cnt_q  <= tail_cnt_d;
    end
  end

endmodule

### rtl/dnsq_fifo.sv
// dnsq_fifo: short queue of parsed words between the parser and the output side
module dnsq_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dnsq_pkg::entry_t wdata_i,
  input  logic             pop_i,
  output dnsq_pkg::entry_t rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned AW = dnsq_pkg::FIFO_AW;

  dnsq_pkg::entry_t  mem_q [dnsq_pkg::FIFO_DEPTH];
  logic [AW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [AW:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == (AW+1)'(dnsq_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (AW+1)'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### rtl/dnsq_back.sv
// dnsq_back: unpacks queue words into result words, one per pop
module dnsq_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dnsq_pkg::entry_t head_i,
  input  logic             fifo_empty_i,
  output logic             fifo_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [1:0]       item_kind_o,
  output logic [15:0]      message_id_o,
  output logic [15:0]      header_flags_o,
  output logic [15:0]      question_count_o,
  output logic [15:0]      answer_count_o,
  output logic [15:0]      authority_count_o,
  output logic [15:0]      additional_count_o,
  output logic [7:0]       name_char_o,
  output logic [15:0]      query_type_o,
  output logic [15:0]      query_class_o,
  output logic [2:0]       error_code_o,
  output logic             last_of_packet_o
);

  logic            sel_q, sel_d;
  logic            show_err;
  logic            final_item;
  logic            taken;
  dnsq_pkg::kind_e kind;

  assign show_err   = !head_i.first_vld || sel_q;
  assign final_item = show_err || !head_i.err_vld;
  assign taken      = pop_i && !fifo_empty_i;
  assign fifo_pop_o = taken && final_item;
  assign empty_o    = fifo_empty_i;
  assign kind       = show_err ? dnsq_pkg::KIND_ERROR : head_i.first_kind;

  always_comb begin
    sel_d = sel_q;
    if (taken) begin
      sel_d = !final_item;
    end
  end

  always_comb begin
    item_kind_o        = kind;
    message_id_o       = '0;
    header_flags_o     = '0;
    question_count_o   = '0;
    answer_count_o     = '0;
    authority_count_o  = '0;
    additional_count_o = '0;
    name_char_o        = '0;
    query_type_o       = '0;
    query_class_o      = '0;
    error_code_o       = '0;
    last_of_packet_o   = head_i.last && final_item;
    unique case (kind)
      dnsq_pkg::KIND_HEADER: begin
        message_id_o       = head_i.words[0];
        header_flags_o     = head_i.words[1];
        question_count_o   = head_i.words[2];
        answer_count_o     = head_i.words[3];
        authority_count_o  = head_i.words[4];
        additional_count_o = head_i.words[5];
      end
      dnsq_pkg::KIND_CHAR: begin
        name_char_o = head_i.chr;
      end
      dnsq_pkg::KIND_DONE: begin
        query_type_o  = head_i.words[0];
        query_class_o = head_i.words[1];
      end
      dnsq_pkg::KIND_ERROR: begin
        error_code_o = head_i.err_code;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

endmodule

### rtl/dnsq_checker.sv
// dnsq_checker: port-level assertions for the dns question parser, with bind
module dnsq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  item_kind_o,
  input logic [15:0] message_id_o,
  input logic [15:0] header_flags_o,
  input logic [15:0] question_count_o,
  input logic [15:0] query_type_o,
  input logic [7:0]  name_char_o,
  input logic [2:0]  error_code_o,
  input logic        last_of_packet_o
);

  // nothing appears on the result side without a byte taken
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty && !(push && !full) |=> empty)
    else $error("result appeared without an accepted byte");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(item_kind_o) && $stable(name_char_o) &&
      $stable(error_code_o) && $stable(last_of_packet_o))
    else $error("stalled result word changed");

  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && item_kind_o == dnsq_pkg::KIND_ERROR |->
      error_code_o <= dnsq_pkg::ERR_TOO_LONG)
    else $error("error code out of range");

  a_hdr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && item_kind_o != dnsq_pkg::KIND_HEADER |->
      message_id_o == 16'd0 && header_flags_o == 16'd0 && question_count_o == 16'd0)
    else $error("header fields not cleared on a non-header word");

  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && item_kind_o == dnsq_pkg::KIND_ERROR |->
      name_char_o == 8'd0 && query_type_o == 16'd0)
    else $error("payload fields not cleared on an error word");

endmodule

bind dns_question_parser dnsq_checker u_dnsq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .push             (push),
  .full             (full),
  .empty            (empty),
  .pop              (pop),
  .item_kind_o      (item_kind_o),
  .message_id_o     (message_id_o),
  .header_flags_o   (header_flags_o),
  .question_count_o (question_count_o),
  .query_type_o     (query_type_o),
  .name_char_o      (name_char_o),
  .error_code_o     (error_code_o),
  .last_of_packet_o (last_of_packet_o)
);

### dv/tb.sv
// tb: self-checking testbench of the dns question parser, with its own parse tracker
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NAME_LIMIT = 255;
  localparam int BYTE_GOAL  = 850;

  typedef enum logic [2:0] {
    STYLE_PLAIN      = 3'd0,
    STYLE_AT_LIMIT   = 3'd1,
    STYLE_LIMIT_PLUS = 3'd2,
    STYLE_OVER       = 3'd3,
    STYLE_POINTER    = 3'd4,
    STYLE_EMPTY      = 3'd5
  } name_style_e;

  typedef struct packed {
    dnsq_pkg::kind_e      kind;
    logic [5:0][15:0]     words;
    logic [7:0]           chr;
    logic [15:0]          qtype;
    logic [15:0]          qclass;
    dnsq_pkg::err_e       code;
    logic                 last;
  } dns_result_t;

  class parse_tracker;
    int               limit;
    int               errors;
    dns_result_t      results_due[$];
    dnsq_pkg::phase_e phase;
    int               hdr_count;
    logic [15:0]      hdr[6];
    logic [15:0]      q_left;
    logic [7:0]       label_left;
    int               name_len;
    bit               started;
    logic [31:0]      tc_shift;
    int               tail_count;

    function new(int name_limit);
      limit  = name_limit;
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase      = dnsq_pkg::PH_HEADER;
      hdr_count  = 0;
      foreach (hdr[i]) hdr[i] = '0;
      q_left     = '0;
      label_left = '0;
      name_len   = 0;
      started    = 1'b0;
      tc_shift   = '0;
      tail_count = 0;
    endfunction

    function void queue_result(dns_result_t r);
      results_due = {results_due, r};
    endfunction

    function dns_result_t blank(dnsq_pkg::kind_e k);
      dns_result_t r;
      r      = '0;
      r.kind = k;
      return r;
    endfunction

    function void add_error(dnsq_pkg::err_e c);
      dns_result_t r;
      r      = blank(dnsq_pkg::KIND_ERROR);
      r.code = c;
      queue_result(r);
      phase = dnsq_pkg::PH_ERROR;
    endfunction

    function void add_char(logic [7:0] c);
      dns_result_t r;
      if (name_len + 1 > limit) begin
        add_error(dnsq_pkg::ERR_TOO_LONG);
      end else begin
        name_len++;
        r     = blank(dnsq_pkg::KIND_CHAR);
        r.chr = c;
        queue_result(r);
      end
    endfunction

    function void note_byte(logic [7:0] b, logic eop);
      int          n0;
      int          idx;
      dns_result_t r;
      n0 = results_due.size();
      case (phase)
        dnsq_pkg::PH_HEADER: begin
          idx = hdr_count >> 1;
          hdr[idx] = {hdr[idx][7:0], b};
          hdr_count++;
          if (hdr_count == 12) begin
            r = blank(dnsq_pkg::KIND_HEADER);
            for (int i = 0; i < 6; i++) r.words[i] = hdr[i];
            queue_result(r);
            q_left = hdr[2];
            if (q_left == 0) add_error(dnsq_pkg::ERR_NO_QUESTIONS);
            else phase = dnsq_pkg::PH_LABEL_LEN;
          end
        end
        dnsq_pkg::PH_LABEL_LEN: begin
          if (b == 8'd0) begin
            if (!started) begin
              add_error(dnsq_pkg::ERR_BAD_NAME);
            end else begin
              phase      = dnsq_pkg::PH_TAIL;
              tail_count = 0;
              tc_shift   = '0;
            end
          end else if (b[7:6] == dnsq_pkg::PTR_MARK) begin
            add_error(dnsq_pkg::ERR_POINTER);
          end else begin
            if (started) add_char(dnsq_pkg::DOT_CHAR);
            if (phase != dnsq_pkg::PH_ERROR) begin
              started    = 1'b1;
              label_left = b;
              phase      = dnsq_pkg::PH_LABEL_BYTES;
            end
          end
        end
        dnsq_pkg::PH_LABEL_BYTES: begin
          add_char(b);
          if (phase != dnsq_pkg::PH_ERROR) begin
            label_left = label_left - 8'd1;
            if (label_left == 8'd0) phase = dnsq_pkg::PH_LABEL_LEN;
          end
        end
        dnsq_pkg::PH_TAIL: begin
          tc_shift = {tc_shift[23:0], b};
          tail_count++;
          if (tail_count == 4) begin
            r        = blank(dnsq_pkg::KIND_DONE);
            r.qtype  = tc_shift[31:16];
            r.qclass = tc_shift[15:0];
            queue_result(r);
            q_left     = q_left - 16'd1;
            tail_count = 0;
            tc_shift   = '0;
            name_len   = 0;
            started    = 1'b0;
            label_left = '0;
            phase      = (q_left == 16'd0) ? dnsq_pkg::PH_DONE : dnsq_pkg::PH_LABEL_LEN;
          end
        end
        default: ;
      endcase
      if (eop) begin
        if (phase == dnsq_pkg::PH_HEADER) begin
          add_error(dnsq_pkg::ERR_SHORT_HEADER);
        end else if (phase == dnsq_pkg::PH_LABEL_LEN ||
                     phase == dnsq_pkg::PH_LABEL_BYTES ||
                     phase == dnsq_pkg::PH_TAIL) begin
          add_error(dnsq_pkg::ERR_BAD_NAME);
        end
        if (results_due.size() > n0) begin
          r      = results_due.pop_back();
          r.last = 1'b1;
          queue_result(r);
        end
        clear_state();
      end
    endfunction

    function void cmp(string fname, logic [15:0] e, logic [15:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, e, a);
      end
    endfunction

    function void check_result(dns_result_t got);
      dns_result_t e;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none actual kind %0d",
                 $time, got.kind);
        return;
      end
      e = results_due.pop_front();
      cmp("item_kind", 16'(e.kind), 16'(got.kind));
      cmp("message_id", e.words[0], got.words[0]);
      cmp("header_flags", e.words[1], got.words[1]);
      cmp("question_count", e.words[2], got.words[2]);
      cmp("answer_count", e.words[3], got.words[3]);
      cmp("authority_count", e.words[4], got.words[4]);
      cmp("additional_count", e.words[5], got.words[5]);
      cmp("name_char", 16'(e.chr), 16'(got.chr));
      cmp("query_type", e.qtype, got.qtype);
      cmp("query_class", e.qclass, got.qclass);
      cmp("error_code", 16'(e.code), 16'(got.code));
      cmp("last_of_packet", 16'(e.last), 16'(got.last));
    endfunction

    function int outstanding();
      return results_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  data_byte;
  logic        end_of_packet;
  logic        empty;
  logic        pop;
  logic [1:0]  item_kind;
  logic [15:0] message_id;
  logic [15:0] header_flags;
  logic [15:0] question_count;
  logic [15:0] answer_count;
  logic [15:0] authority_count;
  logic [15:0] additional_count;
  logic [7:0]  name_char;
  logic [15:0] query_type;
  logic [15:0] query_class;
  logic [2:0]  error_code;
  logic        last_of_packet;

  parse_tracker tracker;
  logic [7:0]   msg_q[$];
  int           bytes_sent;
  bit           calm;

  dns_question_parser #(
    .MAX_NAME_BYTES(NAME_LIMIT)
  ) u_top (
    .clk_i              (clk),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .data_byte_i        (data_byte),
    .end_of_packet_i    (end_of_packet),
    .empty              (empty),
    .pop                (pop),
    .item_kind_o        (item_kind),
    .message_id_o       (message_id),
    .header_flags_o     (header_flags),
    .question_count_o   (question_count),
    .answer_count_o     (answer_count),
    .authority_count_o  (authority_count),
    .additional_count_o (additional_count),
    .name_char_o        (name_char),
    .query_type_o       (query_type),
    .query_class_o      (query_class),
    .error_code_o       (error_code),
    .last_of_packet_o   (last_of_packet)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] rnd16();
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    msg_q = {msg_q, b};
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eop);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push          <= 1'b1;
    data_byte     <= b;
    end_of_packet <= eop;
    do @(posedge clk); while (full);
    tracker.note_byte(b, eop);
  endtask

  task automatic send_msg();
    foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1);
    bytes_sent += msg_q.size();
    msg_q.delete();
  endtask

  task automatic wait_for_results();
    push <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
  endtask

  task automatic add_header(input logic [15:0] id, input logic [15:0] flags,
                            input logic [15:0] qc, input logic [15:0] an,
                            input logic [15:0] ns, input logic [15:0] ar);
    logic [5:0][15:0] w;
    w = {ar, ns, an, qc, flags, id};
    for (int i = 0; i < 6; i++) begin
      put_byte(w[i][15:8]);
      put_byte(w[i][7:0]);
    end
  endtask

  task automatic add_label(input int len);
    put_byte(8'(len));
    repeat (len) put_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic add_question(input name_style_e style);
    int total;
    int len;
    case (style)
      STYLE_PLAIN: begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 19) == 0) add_label($urandom_range(64, 191));
          else add_label($urandom_range(1, 12));
        end
        put_byte(8'd0);
      end
      STYLE_AT_LIMIT, STYLE_LIMIT_PLUS: begin
        repeat (4) add_label(63);
        if (style == STYLE_LIMIT_PLUS) add_label(1);
        put_byte(8'd0);
      end
      STYLE_OVER: begin
        total = -1;
        while (total <= NAME_LIMIT) begin
          len = $urandom_range(40, 191);
          add_label(len);
          total += len + 1;
        end
        put_byte(8'd0);
      end
      STYLE_POINTER: begin
        repeat ($urandom_range(0, 2)) add_label($urandom_range(1, 8));
        put_byte(8'hc0 | 8'($urandom_range(0, 63)));
      end
      default: put_byte(8'd0);
    endcase
    repeat (4) put_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic build_random_msg();
    int r;
    int nq;
    int bad;
    r  = $urandom_range(0, 99);
    nq = $urandom_range(1, 3);
    if (r < 86 && r >= 82) begin
      add_header(rnd16(), rnd16(), 16'd0, rnd16(), rnd16(), rnd16());
      repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
    end else if (r < 90 && r >= 86) begin
      repeat ($urandom_range(1, 11)) put_byte(8'($urandom_range(0, 255)));
    end else begin
      if (r >= 55 && r < 63) begin
        if ($urandom_range(0, 1)) add_header(rnd16(), rnd16(), 16'(nq + $urandom_range(1, 3)),
                                             rnd16(), rnd16(), rnd16());
        else add_header(rnd16(), rnd16(), rnd16() | 16'h0100, rnd16(), rnd16(), rnd16());
      end else begin
        add_header(rnd16(), rnd16(), 16'(nq), rnd16(), rnd16(), rnd16());
      end
      bad = $urandom_range(0, nq - 1);
      for (int q = 0; q < nq; q++) begin
        if (q != bad || r < 71) add_question(STYLE_PLAIN);
        else if (r < 77) add_question(STYLE_POINTER);
        else if (r < 82) add_question(STYLE_EMPTY);
        else if (r < 95) add_question(STYLE_OVER);
        else add_question($urandom_range(0, 1) ? STYLE_LIMIT_PLUS : STYLE_AT_LIMIT);
      end
      if (r < 55 && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 5)) put_byte(8'($urandom_range(0, 255)));
      end
      if (r >= 63 && r < 71) begin
        nq = $urandom_range(1, msg_q.size() - 1);
        while (msg_q.size() > nq) void'(msg_q.pop_back());
      end
    end
  endtask

  initial begin
    dns_result_t got;
    int          stall;
    stall = 0;
    pop   = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        got        = '0;
        got.kind   = dnsq_pkg::kind_e'(item_kind);
        got.words  = {additional_count, authority_count, answer_count,
                      question_count, header_flags, message_id};
        got.chr    = name_char;
        got.qtype  = query_type;
        got.qclass = query_class;
        got.code   = dnsq_pkg::err_e'(error_code);
        got.last   = last_of_packet;
        tracker.check_result(got);
      end
      if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  initial begin
    bit drained;
    push          = 1'b0;
    data_byte     = 8'd0;
    end_of_packet = 1'b0;
    rst_ni        = 1'b0;
    calm          = 1'b0;
    bytes_sent    = 0;
    drained       = 1'b0;
    tracker       = new(NAME_LIMIT);
    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // short header, then a header with no questions, then an empty name
    put_byte(8'hff);
    send_msg();
    add_header(16'hffff, 16'h0000, 16'h0000, 16'hffff, 16'h8001, 16'h7ffe);
    send_msg();
    add_header(16'h0000, 16'hffff, 16'h0001, 16'h0000, 16'h7fff, 16'h8000);
    put_byte(8'd0);
    send_msg();
    wait_for_results();

    while (bytes_sent < BYTE_GOAL) begin
      calm = ($urandom_range(0, 4) == 0);
      build_random_msg();
      send_msg();
      if (!drained && bytes_sent > BYTE_GOAL / 2) begin
        drained = 1'b1;
        wait_for_results();
      end
    end

    wait_for_results();
    repeat (20) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
